// File: sv/dba_pkg.sv
// Shared types, codes and constants of the descriptor bitmap allocator.
// Holds request kinds, result status codes and the eligible-bit mask helper.
// No dependencies.
package dba_pkg;

  localparam int IDX_W          = 10;
  localparam int KIND_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int INDEX_SPAN     = 1024;
  localparam int MAX_WORD_BITS  = 64;

  localparam int MAX_IDS_DEF      = 1024;
  localparam int WORD_BITS_DEF    = 32;
  localparam int RESERVED_LOW_DEF = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLAIM_NAMED = 2'd0,
    KIND_CLAIM_ANY   = 2'd1,
    KIND_RELEASE     = 2'd2,
    KIND_UNUSED      = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BUSY    = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // Bits of map word w that an anonymous claim may hand out.
  function automatic logic [MAX_WORD_BITS-1:0] elig_mask(input int unsigned w,
                                                         input int unsigned wb,
                                                         input int unsigned rl,
                                                         input int unsigned lim);
    logic [MAX_WORD_BITS-1:0] m;
    int unsigned              n;
    m = '0;
    for (int b = 0; b < MAX_WORD_BITS; b++) begin
      n = w * wb + b;
      m[b] = (b < wb) && (n >= rl) && (n < lim);
    end
    return m;
  endfunction

endpackage

// File: sv/descriptor_bitmap_allocator.sv
// Descriptor bitmap allocator: claims and releases descriptor numbers.
// A request that touches the map passes S_READ and S_MOD and shows its
// result on return to idle, a rejected one in the cycle after acceptance.
// busy covers the map read, modify and write-back, and no new request is
// taken while busy. Reset (rst_n, synchronous) frees every number.
// Depends on dba_pkg and dba_map.
module descriptor_bitmap_allocator
  import dba_pkg::*;
#(
  parameter int MAX_IDS      = MAX_IDS_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF,
  parameter int RESERVED_LOW = RESERVED_LOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [IDX_W-1:0]    in_index,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [IDX_W-1:0]    out_granted
);

  localparam int ID_LIMIT  = (MAX_IDS < INDEX_SPAN) ? MAX_IDS : INDEX_SPAN;
  localparam int MAP_WORDS = (ID_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int DIV_SH    = 20;
  localparam int RECIP     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W    = IDX_W + DIV_SH;
  localparam int CMP_W     = IDX_W + 1;
  localparam int GR_W      = IDX_W + 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MOD
  } state_t;

  state_t                state_r;
  kind_t                 kind_r;
  logic [IDX_W-1:0]      idx_r;
  logic [ADDR_W-1:0]     waddr_r;
  logic [BIT_W-1:0]      bit_r;
  logic                  out_strobe_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [IDX_W-1:0]      out_granted_r;

  logic                  accept;
  logic [PROD_W-1:0]     prod;
  logic [ADDR_W-1:0]     in_word;
  logic [IDX_W-1:0]      in_rem;
  logic                  in_range;
  logic                  in_reserved;
  logic                  free_found;
  logic [ADDR_W-1:0]     free_addr;
  logic                  rd_en;
  logic [WORD_BITS-1:0]  rd_data;
  logic                  wr_en;
  logic [WORD_BITS-1:0]  wr_data;
  logic [MAX_WORD_BITS-1:0] any_elig;
  logic [WORD_BITS-1:0]  free_bits;
  logic [BIT_W-1:0]      free_bit;
  logic [WORD_BITS-1:0]  bit_sel;
  logic [GR_W-1:0]       any_gr;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Word number and bit position of the named index.
  assign prod    = PROD_W'(in_index) * PROD_W'(RECIP);
  assign in_word = ADDR_W'(prod >> DIV_SH);
  assign in_rem  = IDX_W'(in_index - IDX_W'(IDX_W'(in_word) * IDX_W'(WORD_BITS)));

  assign in_range    = CMP_W'(in_index) < CMP_W'(ID_LIMIT);
  assign in_reserved = CMP_W'(in_index) < CMP_W'(RESERVED_LOW);

  dba_map #(
    .WORD_BITS    (WORD_BITS),
    .RESERVED_LOW (RESERVED_LOW),
    .ID_LIMIT     (ID_LIMIT),
    .MAP_WORDS    (MAP_WORDS),
    .ADDR_W       (ADDR_W)
  ) u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (rd_en),
    .rd_addr    (waddr_r),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (waddr_r),
    .wr_data    (wr_data),
    .free_found (free_found),
    .free_addr  (free_addr)
  );

  assign rd_en = (state_r == S_READ);

  assign any_elig  = elig_mask(32'(waddr_r), WORD_BITS, RESERVED_LOW, ID_LIMIT);
  assign free_bits = ~rd_data & any_elig[WORD_BITS-1:0];

  always_comb begin
    free_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_bit = BIT_W'(b);
      end
    end
  end

  assign any_gr = GR_W'(GR_W'(waddr_r) * GR_W'(WORD_BITS)) + GR_W'(free_bit);

  always_comb begin
    bit_sel = '0;
    wr_en   = 1'b0;
    wr_data = rd_data;
    if (state_r == S_MOD) begin
      case (kind_r)
        KIND_CLAIM_NAMED: begin
          bit_sel = WORD_BITS'(1) << bit_r;
          wr_en   = !rd_data[bit_r];
          wr_data = rd_data | bit_sel;
        end
        KIND_CLAIM_ANY: begin
          bit_sel = WORD_BITS'(1) << free_bit;
          wr_en   = 1'b1;
          wr_data = rd_data | bit_sel;
        end
        KIND_RELEASE: begin
          bit_sel = WORD_BITS'(1) << bit_r;
          wr_en   = 1'b1;
          wr_data = rd_data & ~bit_sel;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_strobe_r  <= 1'b0;
      kind_r        <= KIND_CLAIM_NAMED;
      out_status_r  <= ST_DONE;
      out_granted_r <= '0;
      idx_r         <= '0;
      waddr_r       <= '0;
      bit_r         <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r        <= kind_t'(in_kind);
            idx_r         <= in_index;
            bit_r         <= BIT_W'(in_rem);
            waddr_r       <= in_word;
            out_granted_r <= '0;
            unique case (kind_t'(in_kind))
              KIND_CLAIM_NAMED: begin
                if (in_range) begin
                  state_r <= S_READ;
                end else begin
                  out_strobe_r <= 1'b1;
                  out_status_r <= ST_FULL;
                end
              end
              KIND_CLAIM_ANY: begin
                waddr_r <= free_addr;
                if (free_found) begin
                  state_r <= S_READ;
                end else begin
                  out_strobe_r <= 1'b1;
                  out_status_r <= ST_FULL;
                end
              end
              KIND_RELEASE: begin
                if (in_range && !in_reserved) begin
                  state_r <= S_READ;
                end else begin
                  out_strobe_r <= 1'b1;
                  out_status_r <= ST_IGNORED;
                end
              end
              default: begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_IGNORED;
              end
            endcase
          end
        end
        S_READ: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          state_r      <= S_IDLE;
          out_strobe_r <= 1'b1;
          case (kind_r)
            KIND_CLAIM_NAMED: begin
              if (rd_data[bit_r]) begin
                out_status_r  <= ST_BUSY;
                out_granted_r <= '0;
              end else begin
                out_status_r  <= ST_DONE;
                out_granted_r <= idx_r;
              end
            end
            KIND_CLAIM_ANY: begin
              out_status_r  <= ST_DONE;
              out_granted_r <= IDX_W'(any_gr);
            end
            default: begin
              out_status_r  <= ST_DONE;
              out_granted_r <= idx_r;
            end
          endcase
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;

`ifndef SYNTH
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while a request is in progress");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(start && !busy) || $past(start && !busy, 3)))
    else $error("result without a matching request");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_DONE) |-> (out_granted == '0))
    else $error("nonzero index on a failed request");

  a_mod_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> ($past(state_r) == S_READ))
    else $error("map write-back without a preceding read");
`endif

endmodule

// File: sv/dba_map.sv
// Used/free bitmap memory of the descriptor allocator with per-word valid
// and full flags, and the lowest non-full word search.
// Depends on dba_pkg.
module dba_map
  import dba_pkg::*;
#(
  parameter int WORD_BITS    = WORD_BITS_DEF,
  parameter int RESERVED_LOW = RESERVED_LOW_DEF,
  parameter int ID_LIMIT     = INDEX_SPAN,
  parameter int MAP_WORDS    = (ID_LIMIT + WORD_BITS - 1) / WORD_BITS,
  parameter int ADDR_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic                 free_found,
  output logic [ADDR_W-1:0]    free_addr
);

  logic [WORD_BITS-1:0]     mem [MAP_WORDS];
  logic [WORD_BITS-1:0]     rd_word_r;
  logic                     rd_vld_r;
  logic [MAP_WORDS-1:0]     vld_r;
  logic [MAP_WORDS-1:0]     full_r;
  logic [MAP_WORDS-1:0]     has_elig;
  logic [MAX_WORD_BITS-1:0] wr_elig_all;
  logic [WORD_BITS-1:0]     wr_elig;
  logic                     wr_full;

  for (genvar g = 0; g < MAP_WORDS; g++) begin : g_elig
    localparam logic [MAX_WORD_BITS-1:0] EMASK =
      elig_mask(g, WORD_BITS, RESERVED_LOW, ID_LIMIT);
    assign has_elig[g] = |EMASK;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign wr_elig_all = elig_mask(32'(wr_addr), WORD_BITS, RESERVED_LOW, ID_LIMIT);
  assign wr_elig     = wr_elig_all[WORD_BITS-1:0];
  assign wr_full     = &(wr_data | ~wr_elig);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      full_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (wr_en) begin
        vld_r[wr_addr]  <= 1'b1;
        full_r[wr_addr] <= wr_full;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

  always_comb begin
    free_found = 1'b0;
    free_addr  = '0;
    for (int w = MAP_WORDS - 1; w >= 0; w--) begin
      if (has_elig[w] && !full_r[w]) begin
        free_found = 1'b1;
        free_addr  = ADDR_W'(w);
      end
    end
  end

endmodule
